>>> design/ipd_pkg.sv
// Shared types, constants and the opcode table for the instruction predecoder.
package ipd_pkg;

	localparam int ADDR_W = 16;
	localparam int MNEM_W = 6;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_WIN_START = 1'b0;
	localparam logic REG_WIN_END   = 1'b1;

	localparam logic [15:0] WIN_START_RST = 16'h00a8;
	localparam logic [15:0] WIN_END_RST   = 16'h00e0;

	// Opcodes with special handling
	localparam logic [7:0] OP_CB    = 8'hcb;
	localparam logic [7:0] OP_JR    = 8'h18;
	localparam logic [7:0] OP_JR_NZ = 8'h20;
	localparam logic [7:0] OP_JR_Z  = 8'h28;
	localparam logic [7:0] OP_JR_NC = 8'h30;
	localparam logic [7:0] OP_JR_C  = 8'h38;

	// Recognized second bytes after the CB prefix
	localparam logic [7:0] CB_RL_C   = 8'h11;
	localparam logic [7:0] CB_BIT1_A = 8'h4f;
	localparam logic [7:0] CB_BIT7_H = 8'h7c;

	// Mnemonic codes
	localparam logic [MNEM_W-1:0] MN_DATA    = 6'd0;
	localparam logic [MNEM_W-1:0] MN_UNKNOWN = 6'd1;
	localparam logic [MNEM_W-1:0] MN_UNK_CB  = 6'd2;
	localparam logic [MNEM_W-1:0] MN_RL_C    = 6'd47;
	localparam logic [MNEM_W-1:0] MN_BIT1_A  = 6'd48;
	localparam logic [MNEM_W-1:0] MN_BIT7_H  = 6'd49;

	// Length markers in bits 7:6 of a table entry
	localparam logic [1:0] LM1 = 2'd0;
	localparam logic [1:0] LM2 = 2'd1;
	localparam logic [1:0] LM3 = 2'd2;

	typedef enum logic [1:0] {
		PH_OPCODE = 2'd0,
		PH_OPER1  = 2'd1,
		PH_OPER2  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] win_start;
		logic [15:0] win_end;
	} ipd_cfg_t;

	typedef struct packed {
		logic              valid;
		logic [15:0]       start_address;
		logic [MNEM_W-1:0] mnemonic;
		logic [7:0]        opcode_byte;
		logic [7:0]        prefixed_byte;
		logic [15:0]       immediate;
		logic [15:0]       jump_target;
		logic [1:0]        length;
	} ipd_result_t;

	// Table entry: length marker in 7:6, mnemonic code in 5:0; zero means unknown
	function automatic logic [7:0] op_entry(input logic [7:0] op);
		logic [7:0] e;
		case (op)
			8'h04: e = {LM1, 6'd3};
			8'h05: e = {LM1, 6'd4};
			8'h06: e = {LM2, 6'd5};
			8'h0c: e = {LM1, 6'd6};
			8'h0d: e = {LM1, 6'd7};
			8'h0e: e = {LM2, 6'd8};
			8'h11: e = {LM3, 6'd9};
			8'h13: e = {LM1, 6'd10};
			8'h15: e = {LM1, 6'd11};
			8'h16: e = {LM2, 6'd12};
			8'h17: e = {LM1, 6'd13};
			8'h18: e = {LM2, 6'd14};
			8'h1a: e = {LM1, 6'd15};
			8'h1d: e = {LM1, 6'd16};
			8'h1e: e = {LM2, 6'd17};
			8'h20: e = {LM2, 6'd18};
			8'h21: e = {LM3, 6'd19};
			8'h22: e = {LM1, 6'd20};
			8'h23: e = {LM1, 6'd21};
			8'h24: e = {LM1, 6'd22};
			8'h28: e = {LM2, 6'd23};
			8'h2e: e = {LM2, 6'd24};
			8'h30: e = {LM2, 6'd25};
			8'h31: e = {LM3, 6'd26};
			8'h32: e = {LM1, 6'd27};
			8'h38: e = {LM2, 6'd28};
			8'h3d: e = {LM1, 6'd29};
			8'h3e: e = {LM2, 6'd30};
			8'h47: e = {LM1, 6'd31};
			8'h4f: e = {LM1, 6'd32};
			8'h57: e = {LM1, 6'd33};
			8'h67: e = {LM1, 6'd34};
			8'h77: e = {LM1, 6'd35};
			8'h78: e = {LM1, 6'd36};
			8'h7b: e = {LM1, 6'd37};
			8'h7c: e = {LM1, 6'd38};
			8'h7d: e = {LM1, 6'd39};
			8'h86: e = {LM1, 6'd40};
			8'h90: e = {LM1, 6'd41};
			8'haf: e = {LM1, 6'd42};
			8'hbe: e = {LM1, 6'd43};
			8'hc1: e = {LM1, 6'd44};
			8'hc5: e = {LM1, 6'd45};
			8'hc9: e = {LM1, 6'd46};
			8'hcb: e = {LM2, MN_UNK_CB};
			8'hcd: e = {LM3, 6'd50};
			8'hd5: e = {LM1, 6'd51};
			8'he0: e = {LM2, 6'd52};
			8'he2: e = {LM1, 6'd53};
			8'he5: e = {LM1, 6'd54};
			8'hea: e = {LM3, 6'd55};
			8'hf0: e = {LM2, 6'd56};
			8'hf5: e = {LM1, 6'd57};
			8'hfe: e = {LM2, 6'd58};
			default: e = 8'h00;
		endcase
		return e;
	endfunction

	function automatic logic [1:0] entry_len(input logic [7:0] e);
		logic [1:0] len;
		if (e[7])
			len = 2'd3;
		else if (e[6])
			len = 2'd2;
		else
			len = 2'd1;
		return len;
	endfunction

endpackage

>>> design/ipd_cfg_regs.sv
// APB-style configuration registers holding the raw data window bounds.
module ipd_cfg_regs
	import ipd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output ipd_cfg_t    cfg
);

	logic [15:0] win_start_q;
	logic [15:0] win_end_q;
	logic        wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= WIN_START_RST;
			win_end_q   <= WIN_END_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_WIN_START: win_start_q <= pwdata[15:0];
				REG_WIN_END:   win_end_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIN_START: prdata = {16'h0000, win_start_q};
			REG_WIN_END:   prdata = {16'h0000, win_end_q};
			default:       prdata = 32'h0000_0000;
		endcase
	end

	assign cfg.win_start = win_start_q;
	assign cfg.win_end   = win_end_q;

endmodule

>>> design/ipd_decode.sv
// Byte-wise phase machine: tracks position and operands, builds one result per instruction or data byte.
module ipd_decode
	import ipd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  image_byte,
	input  logic        image_end,
	input  ipd_cfg_t    cfg,
	output ipd_result_t res
);

	logic [15:0] pos_q, pos_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  op_q, op_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] start_q, start_d;
	logic        in_window;

	function automatic ipd_result_t emit_instr(input logic [15:0] start, input logic [7:0] op,
			input logic [7:0] b1, input logic [7:0] b2);
		ipd_result_t r;
		logic [7:0]  e;
		logic [1:0]  len;
		e   = op_entry(op);
		len = entry_len(e);
		r   = '0;
		r.valid         = 1'b1;
		r.start_address = start;
		r.opcode_byte   = op;
		if (op == OP_CB) begin
			r.length        = 2'd2;
			r.prefixed_byte = b1;
			case (b1)
				CB_RL_C:   r.mnemonic = MN_RL_C;
				CB_BIT1_A: r.mnemonic = MN_BIT1_A;
				CB_BIT7_H: r.mnemonic = MN_BIT7_H;
				default:   r.mnemonic = MN_UNK_CB;
			endcase
		end else if (e[MNEM_W-1:0] == MN_DATA) begin
			r.mnemonic = MN_UNKNOWN;
			r.length   = 2'd1;
		end else begin
			r.mnemonic = e[MNEM_W-1:0];
			r.length   = len;
			if (len == 2'd2) begin
				r.immediate = {8'h00, b1};
				if (op inside {OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C})
					r.jump_target = start + 16'd2 + {{8{b1[7]}}, b1};
			end else if (len == 2'd3) begin
				r.immediate = {b2, b1};
			end
		end
		return r;
	endfunction

	assign in_window = (pos_q >= cfg.win_start) && (pos_q < cfg.win_end);

	always_comb begin
		res     = '0;
		phase_d = PH_OPCODE;
		op_d    = op_q;
		low_d   = low_q;
		start_d = start_q;
		pos_d   = pos_q + 16'd1;
		case (phase_q)
			PH_OPER1: begin
				if (op_q != OP_CB && entry_len(op_entry(op_q)) == 2'd3) begin
					low_d   = image_byte;
					phase_d = PH_OPER2;
				end else begin
					res = emit_instr(start_q, op_q, image_byte, 8'h00);
				end
			end
			PH_OPER2: begin
				res = emit_instr(start_q, op_q, low_q, image_byte);
			end
			default: begin
				start_d = pos_q;
				op_d    = image_byte;
				low_d   = 8'h00;
				if (in_window) begin
					res.valid         = 1'b1;
					res.start_address = pos_q;
					res.mnemonic      = MN_DATA;
					res.opcode_byte   = image_byte;
					res.length        = 2'd1;
				end else if (entry_len(op_entry(image_byte)) == 2'd1) begin
					res = emit_instr(pos_q, image_byte, 8'h00, 8'h00);
				end else begin
					phase_d = PH_OPER1;
				end
			end
		endcase
		// Flush an instruction cut short by the end of the image, then restart
		if (image_end) begin
			if (!res.valid && phase_d == PH_OPER1)
				res = emit_instr(start_d, op_d, 8'h00, 8'h00);
			else if (!res.valid && phase_d == PH_OPER2)
				res = emit_instr(start_d, op_d, low_d, 8'h00);
			pos_d   = 16'h0000;
			phase_d = PH_OPCODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 16'h0000;
			phase_q <= PH_OPCODE;
			op_q    <= 8'h00;
			low_q   <= 8'h00;
			start_q <= 16'h0000;
		end else if (step) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			op_q    <= op_d;
			low_q   <= low_d;
			start_q <= start_d;
		end
	end

`ifndef SYNTHESIS
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && image_end |=> pos_q == 16'h0000 && phase_q == PH_OPCODE)
		else $error("position or phase not restarted after end of image");
	a_pending_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && !image_end && phase_d != PH_OPCODE |-> !res.valid)
		else $error("result produced while an instruction is still pending");
	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		step && image_end && phase_q != PH_OPCODE |-> res.valid)
		else $error("incomplete instruction not flushed at end of image");
`endif

endmodule

>>> design/cpu_instruction_predecoder.sv
// Top level of the instruction predecoder: input stage, decoder, result register, config port.
//
// Program image bytes enter on the input channel (in_valid/in_ready, image_byte,
// image_end); one transfer carries one byte, and image_end marks the last byte.
// Each instruction and each data-window byte leaves as one transfer on the output channel
// (out_valid/out_ready) with its address, mnemonic code, opcode, CB second byte,
// immediate, relative jump target and length. Operand bytes give no result.
// A byte is taken into the input register, decoded there by the phase machine, and its
// result is loaded into the output register when the decoder advances.
// Throughput: one byte per cycle while the receiver does not stall; the phase machine and
// opcode table decode a byte combinationally between the input and the output register.
// When the receiver stalls, the output register holds its result and the
// decoder holds too; the input register still takes a byte only if it is empty, and
// in_ready stays low while it holds one, until the stall clears.
// Reset clears position, phase and both stages, and loads the data window with its default
// bounds 0x00a8 to 0x00e0. Window registers are written over the APB port at byte addresses
// 0 and 4, by the user only while the block is idle; the block does not enforce this.
module cpu_instruction_predecoder
	import ipd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        image_byte,
	input  logic              image_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       start_address,
	output logic [MNEM_W-1:0] mnemonic,
	output logic [7:0]        opcode_byte,
	output logic [7:0]        prefixed_byte,
	output logic [15:0]       immediate,
	output logic [15:0]       jump_target,
	output logic [1:0]        length
);

	ipd_cfg_t    cfg;
	ipd_result_t res;
	ipd_result_t res_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_free;
	logic        advance;

	ipd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipd_decode u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.image_byte (byte_s1),
		.image_end  (last_s1),
		.cfg        (cfg),
		.res        (res)
	);

	assign out_free = !res_q.valid || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= image_byte;
			last_s1 <= image_end;
		end
	end

	// Result register: load whenever the decoder advances, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_q <= '0;
		else if (advance)
			res_q <= res;
		else if (out_free)
			res_q.valid <= 1'b0;
	end

	assign out_valid     = res_q.valid;
	assign start_address = res_q.start_address;
	assign mnemonic      = res_q.mnemonic;
	assign opcode_byte   = res_q.opcode_byte;
	assign prefixed_byte = res_q.prefixed_byte;
	assign immediate     = res_q.immediate;
	assign jump_target   = res_q.jump_target;
	assign length        = res_q.length;

`ifndef SYNTHESIS
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length != 2'd0)
		else $error("result with zero length");
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mnemonic == MN_DATA |-> length == 2'd1 && immediate == 16'h0000
			&& jump_target == 16'h0000 && prefixed_byte == 8'h00)
		else $error("data byte result carries operand fields");
	a_prefix_only_cb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prefixed_byte != 8'h00 |-> opcode_byte == OP_CB && length == 2'd2)
		else $error("prefixed byte on a non-CB result");
	a_stall_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !advance)
		else $error("decoder advanced while result register is held");
`endif

endmodule
